@@ hdl/jse_pkg.sv @@
package jse_pkg;

   // default depth of the queue between classifier and emitter
   localparam int QUEUE_DEPTH = 2;

   // ascii codes used in escape sequences
   localparam logic [7:0] CHR_NUL       = 8'h00;
   localparam logic [7:0] CHR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHR_RETURN    = 8'h0D;
   localparam logic [7:0] CHR_QUOTE     = 8'h22;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_ZERO      = 8'h30;
   localparam logic [7:0] CHR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHR_LOWER_U   = 8'h75;

   // emitter step numbers within an escape sequence
   localparam logic [2:0] STEP_SECOND = 3'd1;
   localparam logic [2:0] STEP_THIRD  = 3'd2;
   localparam logic [2:0] STEP_FOURTH = 3'd3;
   localparam logic [2:0] STEP_FIFTH  = 3'd4;
   localparam logic [2:0] STEP_SIXTH  = 3'd5;

   // how a byte is rendered
   typedef enum logic [1:0] {
      ESC_PASS,
      ESC_SHORT,
      ESC_UNICODE
   } esc_kind_type;

   // classified byte: for short escapes value holds the letter
   typedef struct packed {
      esc_kind_type kind;
      logic [7:0]   value;
   } esc_desc_type;

   // queue write side
   typedef struct packed {
      logic         valid;
      esc_desc_type desc;
   } esc_push_type;

   // lower-case hex digit of a nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] digit;
      case (nibble)
         4'h0: digit = 8'h30;
         4'h1: digit = 8'h31;
         4'h2: digit = 8'h32;
         4'h3: digit = 8'h33;
         4'h4: digit = 8'h34;
         4'h5: digit = 8'h35;
         4'h6: digit = 8'h36;
         4'h7: digit = 8'h37;
         4'h8: digit = 8'h38;
         4'h9: digit = 8'h39;
         4'hA: digit = 8'h61;
         4'hB: digit = 8'h62;
         4'hC: digit = 8'h63;
         4'hD: digit = 8'h64;
         4'hE: digit = 8'h65;
         default: digit = 8'h66;
      endcase
      return digit;
   endfunction

endpackage

@@ hdl/jse_intf.sv @@
// input byte channel
interface jse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

// escaped byte channel
interface jse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

@@ hdl/jse_front.sv @@
module jse_front (
   jse_req_if.sink               req_ch,
   input  logic                  full,
   output jse_pkg::esc_push_type push
);

   jse_pkg::esc_desc_type desc;

   // classify the incoming byte
   always_comb begin
      desc.kind  = jse_pkg::ESC_SHORT;
      desc.value = req_ch.in_byte;
      unique case (req_ch.in_byte)
         jse_pkg::CHR_BACKSPACE: desc.value = jse_pkg::CHR_LOWER_B;
         jse_pkg::CHR_NEWLINE:   desc.value = jse_pkg::CHR_LOWER_N;
         jse_pkg::CHR_RETURN:    desc.value = jse_pkg::CHR_LOWER_R;
         jse_pkg::CHR_TAB:       desc.value = jse_pkg::CHR_LOWER_T;
         jse_pkg::CHR_QUOTE:     desc.value = jse_pkg::CHR_QUOTE;
         jse_pkg::CHR_BACKSLASH: desc.value = jse_pkg::CHR_BACKSLASH;
         default: begin
            if (req_ch.in_byte < jse_pkg::CHR_SPACE) begin
               desc.kind = jse_pkg::ESC_UNICODE;
            end else begin
               desc.kind = jse_pkg::ESC_PASS;
            end
         end
      endcase
   end

   // take a transfer whenever the queue has room; end-of-string bytes are dropped
   assign req_ch.ready = !full;
   assign push.valid   = req_ch.valid && !full && (req_ch.in_byte != jse_pkg::CHR_NUL);
   assign push.desc    = desc;

endmodule

@@ hdl/jse_queue.sv @@
module jse_queue #(
   parameter int Depth = jse_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  jse_pkg::esc_push_type push,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output jse_pkg::esc_desc_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   jse_pkg::esc_desc_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.desc;
      end
   end

endmodule

@@ hdl/jse_back.sv @@
module jse_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   input  jse_pkg::esc_desc_type head,
   output logic                  pop,
   jse_rsp_if.source             rsp_ch
);

   logic                  busy_ff, busy_in;
   logic [2:0]            step_ff, step_in;
   jse_pkg::esc_desc_type cur_ff, cur_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_free;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign pop      = out_free && !busy_ff && !empty;

   // emit one byte per free output slot
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (out_free) begin
         if (busy_ff) begin
            out_valid_in = 1'b1;
            out_last_in  = 1'b0;
            step_in      = step_ff + 1'b1;
            if (cur_ff.kind == jse_pkg::ESC_SHORT) begin
               out_byte_in = cur_ff.value;
               out_last_in = 1'b1;
               busy_in     = 1'b0;
            end else begin
               unique case (step_ff)
                  jse_pkg::STEP_SECOND: out_byte_in = jse_pkg::CHR_LOWER_U;
                  jse_pkg::STEP_THIRD:  out_byte_in = jse_pkg::CHR_ZERO;
                  jse_pkg::STEP_FOURTH: out_byte_in = jse_pkg::CHR_ZERO;
                  jse_pkg::STEP_FIFTH:  out_byte_in = jse_pkg::hex_digit(cur_ff.value[7:4]);
                  default: begin
                     out_byte_in = jse_pkg::hex_digit(cur_ff.value[3:0]);
                     out_last_in = 1'b1;
                     busy_in     = 1'b0;
                  end
               endcase
            end
         end else if (!empty) begin
            out_valid_in = 1'b1;
            cur_in       = head;
            step_in      = jse_pkg::STEP_SECOND;
            if (head.kind == jse_pkg::ESC_PASS) begin
               out_byte_in = head.value;
               out_last_in = 1'b1;
            end else begin
               out_byte_in = jse_pkg::CHR_BACKSLASH;
               out_last_in = 1'b0;
               busy_in     = 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;
   assign rsp_ch.out_last = out_last_ff;

endmodule

@@ hdl/json_string_escaper_top.sv @@
// channel   dir   payload                      handshake
// req_ch    in    in_byte[7:0]                 valid / ready
// rsp_ch    out   out_byte[7:0], out_last      valid / ready
//
// a plain byte is emitted as itself; a short escape as two bytes, a \u00xx escape as six,
// one output byte per cycle while rsp_ch accepts, set by the single output register.
// end-of-string bytes are taken and dropped, so they produce no output byte.
// input is taken while the classified-byte queue has room, so the front
// keeps accepting while the output waits; synchronous reset empties the queue.
module json_string_escaper_top #(
   parameter int QueueDepth = jse_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   jse_req_if.sink     req_ch,
   jse_rsp_if.source   rsp_ch
);

   jse_pkg::esc_push_type push;
   jse_pkg::esc_desc_type head;
   logic                  full;
   logic                  empty;
   logic                  pop;

   // classify input bytes
   jse_front u_front (
      .req_ch (req_ch),
      .full   (full),
      .push   (push)
   );

   // decouple classification from emission
   jse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (full),
      .empty (empty),
      .head  (head)
   );

   // emit escaped bytes
   jse_back u_back (
      .clock  (clock),
      .reset  (reset),
      .empty  (empty),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
